// ===== rtl/apsd_pkg.sv =====
// apsd_pkg: shared item types, status codes and framing constants for the app4 segment payload deframer
// no dependencies; imported by apsd_parse, the top level and the testbench
package apsd_pkg;

  localparam logic [7:0]  SYNC_BYTE      = 8'hFF;   // first byte of every marker pair
  localparam logic [7:0]  MARKER_RESET   = 8'd228;  // app4 marker code
  localparam logic [15:0] FRAME_OVERHEAD = 16'd6;   // length field plus size field
  localparam logic [15:0] MIN_HDR_LEN    = 16'd4;   // header must hold its own length bytes
  localparam logic [15:0] LEN_FIELD_LEN  = 16'd2;   // later segment length counts itself
  localparam logic [31:0] TAIL_MIN       = 32'd4;   // smallest tail worth a new segment
  localparam int unsigned COUNT_BITS     = 24;      // width of out_count field

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_MARKER    = 3'd1,
    ST_MISSING_MARK = 3'd2,
    ST_SHORT_TAIL   = 3'd3,
    ST_HDR_SHORT    = 3'd4,
    ST_CUT          = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]            data_byte;
    logic                  byte_valid;
    logic                  packet_end;
    logic [2:0]            status;
    logic [COUNT_BITS-1:0] out_count;
  } out_item_t;

endpackage

// ===== rtl/apsd_parse.sv =====
// apsd_parse: per-packet parser state and single-pass next-state logic
// depends on apsd_pkg; one item is processed on each fire_i strobe
module apsd_parse #(
  parameter int unsigned OUT_COUNT_WIDTH = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  apsd_pkg::in_item_t item_i,
  input  logic [7:0]         marker_i,
  output logic               has_result_o,
  output apsd_pkg::out_item_t result_o
);
  import apsd_pkg::*;

  typedef enum logic [7:0] {
    PH_SEARCH = 8'b0000_0001,
    PH_LEN    = 8'b0000_0010,
    PH_HEADER = 8'b0000_0100,
    PH_SIZE   = 8'b0000_1000,
    PH_DATA   = 8'b0001_0000,
    PH_MARK   = 8'b0010_0000,
    PH_DONE   = 8'b0100_0000,
    PH_DRAIN  = 8'b1000_0000
  } phase_e;

  localparam logic [OUT_COUNT_WIDTH-1:0] CountMax = '1;

  phase_e                     phase_q, phase_d;
  status_e                    status_q, status_d;
  logic                       prev_ff_q, prev_ff_d;
  logic [1:0]                 field_idx_q, field_idx_d;
  logic [15:0]                app_len_q, app_len_d;
  logic [15:0]                hdr_len_q, hdr_len_d;
  logic [15:0]                hdr_cnt_q, hdr_cnt_d;
  logic [31:0]                remain_q, remain_d;   // payload size minus bytes consumed
  logic [15:0]                seg_left_q, seg_left_d;
  logic                       later_q, later_d;
  logic [OUT_COUNT_WIDTH-1:0] emit_cnt_q, emit_cnt_d;

  logic        emit;
  logic [31:0] rem_dec;
  logic        done_after;
  logic        short_after;
  logic [15:0] cnt_inc;
  logic [15:0] seg_len;
  status_e     status_out;
  logic [31:0] cnt_ext;

  always_comb begin
    phase_d     = phase_q;
    status_d    = status_q;
    prev_ff_d   = prev_ff_q;
    field_idx_d = field_idx_q;
    app_len_d   = app_len_q;
    hdr_len_d   = hdr_len_q;
    hdr_cnt_d   = hdr_cnt_q;
    remain_d    = remain_q;
    seg_left_d  = seg_left_q;
    later_d     = later_q;
    emit        = 1'b0;
    cnt_inc     = hdr_cnt_q + 16'd1;
    seg_len     = '0;
    // remaining size after consuming one byte, and the checks on it
    rem_dec     = remain_q - {31'd0, (remain_q != '0)};
    done_after  = (remain_q <= 32'd1);
    short_after = (remain_q <= TAIL_MIN);

    case (phase_q)
      PH_SEARCH: begin
        if (prev_ff_q && (item_i.in_byte == marker_i) && !item_i.in_last) begin
          phase_d     = PH_LEN;
          field_idx_d = '0;
        end
        prev_ff_d = (item_i.in_byte == SYNC_BYTE);
      end
      PH_LEN: begin
        app_len_d = {app_len_q[7:0], item_i.in_byte};
        if (field_idx_q == 2'd1) begin
          phase_d   = PH_HEADER;
          hdr_cnt_d = '0;
        end else begin
          field_idx_d = 2'd1;
        end
      end
      PH_HEADER: begin
        if (hdr_cnt_q == 16'd2) begin
          hdr_len_d = {8'd0, item_i.in_byte};
        end else if (hdr_cnt_q == 16'd3) begin
          hdr_len_d = {item_i.in_byte, hdr_len_q[7:0]};
        end
        hdr_cnt_d = cnt_inc;
        if ((cnt_inc == MIN_HDR_LEN) && (hdr_len_d < MIN_HDR_LEN)) begin
          phase_d  = PH_DRAIN;
          status_d = ST_HDR_SHORT;
        end else if ((cnt_inc >= MIN_HDR_LEN) && (cnt_inc == hdr_len_d)) begin
          phase_d     = PH_SIZE;
          field_idx_d = '0;
        end
      end
      PH_SIZE: begin
        remain_d[{field_idx_q, 3'b000} +: 8] = item_i.in_byte;
        if (field_idx_q == 2'd3) begin
          seg_len    = app_len_q - hdr_len_q - FRAME_OVERHEAD;
          seg_left_d = seg_len;
          later_d    = 1'b0;
          if (seg_len != '0) begin
            phase_d = PH_DATA;
          end else if (remain_d == '0) begin
            phase_d = PH_DONE;
          end else begin
            phase_d     = PH_MARK;
            field_idx_d = '0;
          end
        end else begin
          field_idx_d = field_idx_q + 2'd1;
        end
      end
      PH_DATA: begin
        emit       = 1'b1;
        remain_d   = rem_dec;
        seg_left_d = seg_left_q - 16'd1;
        if (seg_left_d == '0) begin
          if (done_after) begin
            phase_d = PH_DONE;
          end else if (later_q && short_after) begin
            phase_d  = PH_DRAIN;
            status_d = ST_SHORT_TAIL;
          end else begin
            phase_d     = PH_MARK;
            field_idx_d = '0;
          end
        end
      end
      PH_MARK: begin
        remain_d = rem_dec;
        case (field_idx_q)
          2'd0: begin
            if (item_i.in_byte != SYNC_BYTE) begin
              phase_d  = PH_DRAIN;
              status_d = ST_MISSING_MARK;
            end else begin
              field_idx_d = 2'd1;
            end
          end
          2'd1: begin
            if (item_i.in_byte != marker_i) begin
              phase_d  = PH_DRAIN;
              status_d = ST_MISSING_MARK;
            end else begin
              field_idx_d = 2'd2;
            end
          end
          2'd2: begin
            seg_left_d  = {item_i.in_byte, 8'd0};
            field_idx_d = 2'd3;
          end
          default: begin
            // length counts its own two bytes
            seg_len    = {seg_left_q[15:8], item_i.in_byte} - LEN_FIELD_LEN;
            seg_left_d = seg_len;
            later_d    = 1'b1;
            if (seg_len != '0) begin
              phase_d = PH_DATA;
            end else if (done_after) begin
              phase_d = PH_DONE;
            end else if (short_after) begin
              phase_d  = PH_DRAIN;
              status_d = ST_SHORT_TAIL;
            end else begin
              phase_d     = PH_MARK;
              field_idx_d = '0;
            end
          end
        endcase
      end
      default: begin
        // done and drain drop bytes until packet end
      end
    endcase

    emit_cnt_d = emit_cnt_q;
    if (emit && (emit_cnt_q != CountMax)) begin
      emit_cnt_d = emit_cnt_q + 1'b1;
    end

    // closing status, when no error was flagged earlier
    status_out = status_d;
    if (status_d == ST_OK) begin
      if (phase_d == PH_SEARCH) begin
        status_out = ST_NO_MARKER;
      end else if (phase_d inside {PH_LEN, PH_HEADER, PH_SIZE, PH_DATA}) begin
        status_out = ST_CUT;
      end else if ((phase_d == PH_MARK) && (field_idx_d != '0)) begin
        status_out = ST_SHORT_TAIL;
      end
    end
  end

  assign cnt_ext = 32'(emit_cnt_d);

  assign has_result_o         = emit || item_i.in_last;
  assign result_o.data_byte   = emit ? item_i.in_byte : 8'd0;
  assign result_o.byte_valid  = emit;
  assign result_o.packet_end  = item_i.in_last;
  assign result_o.status      = item_i.in_last ? status_out : ST_OK;
  assign result_o.out_count   = cnt_ext[COUNT_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SEARCH;
      status_q    <= ST_OK;
      prev_ff_q   <= 1'b0;
      field_idx_q <= '0;
      app_len_q   <= '0;
      hdr_len_q   <= '0;
      hdr_cnt_q   <= '0;
      remain_q    <= '0;
      seg_left_q  <= '0;
      later_q     <= 1'b0;
      emit_cnt_q  <= '0;
    end else if (fire_i) begin
      if (item_i.in_last) begin
        phase_q     <= PH_SEARCH;
        status_q    <= ST_OK;
        prev_ff_q   <= 1'b0;
        field_idx_q <= '0;
        app_len_q   <= '0;
        hdr_len_q   <= '0;
        hdr_cnt_q   <= '0;
        remain_q    <= '0;
        seg_left_q  <= '0;
        later_q     <= 1'b0;
        emit_cnt_q  <= '0;
      end else begin
        phase_q     <= phase_d;
        status_q    <= status_d;
        prev_ff_q   <= prev_ff_d;
        field_idx_q <= field_idx_d;
        app_len_q   <= app_len_d;
        hdr_len_q   <= hdr_len_d;
        hdr_cnt_q   <= hdr_cnt_d;
        remain_q    <= remain_d;
        seg_left_q  <= seg_left_d;
        later_q     <= later_d;
        emit_cnt_q  <= emit_cnt_d;
      end
    end
  end

endmodule

// ===== rtl/app4_segment_payload_deframer_unit.sv =====
// app4 segment payload deframer: input stage register, then result register
// one byte per cycle while the result register is free; single-pass parser between two registers
// an input item that causes no result is consumed without occupying the output register
// reset (async, active low) clears the parser state, both stage valids and
// sets the marker register to the app4 code; the parser state clears again after every packet end
module app4_segment_payload_deframer_unit #(
  parameter int unsigned OUT_COUNT_WIDTH = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input byte stream
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  apsd_pkg::in_item_t  in_item_i,
  // payload result stream
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output apsd_pkg::out_item_t out_item_o,
  // marker code register write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);
  import apsd_pkg::*;

  // marker code register, always writable
  logic [7:0] marker_q;

  // input stage
  logic       s1_valid_q;
  in_item_t   s1_item_q;

  // result stage
  logic       out_valid_q;
  out_item_t  out_item_q;

  logic       out_free;    // result register can take a new item this cycle
  logic       s1_fire;     // input stage item is processed this cycle
  logic       has_result;
  out_item_t  result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= MARKER_RESET;
    end else if (cfg_valid_i) begin
      marker_q <= cfg_data_i;
    end
  end

  // the input stage drains only when the result register is free, so a waiting
  // result stalls the stream even when the next item would produce no result
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
  end

  apsd_parse #(
    .OUT_COUNT_WIDTH (OUT_COUNT_WIDTH)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (s1_fire),
    .item_i       (s1_item_q),
    .marker_i     (marker_q),
    .has_result_o (has_result),
    .result_o     (result)
  );

  // result register, loaded only with items that produce a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_fire && has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_fire && has_result) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== sim/apsd_deframe_checker.sv =====
`timescale 1ns / 1ps
// apsd_deframe_checker: watches the byte, result and marker write channels of the deframer,
// predicts every result and compares it field by field; depends on apsd_pkg only
module apsd_deframe_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  apsd_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  apsd_pkg::out_item_t out_item_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [7:0]          cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o
);
  import apsd_pkg::*;

  typedef enum logic [3:0] {
    P_HUNT, P_LEN, P_HDR, P_SIZE, P_FIRST, P_MARK, P_SEG, P_DONE, P_DRAIN
  } parse_phase_e;

  logic [7:0]            marker_code;
  parse_phase_e          phase;
  logic                  prev_ff;
  logic [1:0]            fld;
  logic [15:0]           app_len;
  logic [15:0]           hdr_len;
  logic [15:0]           hdr_cnt;
  logic [31:0]           pay_total;
  logic [32:0]           pay_used;
  logic [15:0]           seg_left;
  logic                  later;
  logic [2:0]            pkt_status;
  logic [COUNT_BITS-1:0] emitted;

  out_item_t deframed_q[$];
  out_item_t next_res;

  function automatic void clear_packet();
    phase      = P_HUNT;
    prev_ff    = 1'b0;
    fld        = '0;
    app_len    = '0;
    hdr_len    = '0;
    hdr_cnt    = '0;
    pay_total  = '0;
    pay_used   = '0;
    seg_left   = '0;
    later      = 1'b0;
    pkt_status = ST_OK;
    emitted    = '0;
  endfunction

  function automatic void abort_packet(input logic [2:0] code);
    pkt_status = code;
    phase      = P_DRAIN;
  endfunction

  function automatic void close_segment();
    if ({1'b0, pay_total} <= pay_used) begin
      phase = P_DONE;
    end else if (later && ({1'b0, pay_total} - pay_used) < {1'b0, TAIL_MIN}) begin
      abort_packet(ST_SHORT_TAIL);
    end else begin
      phase = P_MARK;
      fld   = '0;
    end
  endfunction

  function automatic void open_segment();
    if (seg_left == '0) close_segment();
    else phase = later ? P_SEG : P_FIRST;
  endfunction

  // one packet byte in, zero or one result out
  function automatic bit deframe_byte(input logic [7:0] b, input logic lst,
                                      output out_item_t res);
    bit emit;
    emit = 1'b0;
    case (phase)
      P_HUNT: begin
        if (prev_ff && b == marker_code && !lst) begin
          phase = P_LEN;
          fld   = '0;
        end
        prev_ff = (b == SYNC_BYTE);
      end
      P_LEN: begin
        app_len = {app_len[7:0], b};
        if (fld == 2'd1) begin
          phase   = P_HDR;
          hdr_cnt = '0;
        end else begin
          fld = 2'd1;
        end
      end
      P_HDR: begin
        if (hdr_cnt == 16'd2) hdr_len = {8'h00, b};
        else if (hdr_cnt == 16'd3) hdr_len = {b, hdr_len[7:0]};
        hdr_cnt = hdr_cnt + 16'd1;
        if (hdr_cnt == 16'd4 && hdr_len < MIN_HDR_LEN) begin
          abort_packet(ST_HDR_SHORT);
        end else if (hdr_cnt >= 16'd4 && hdr_cnt == hdr_len) begin
          phase = P_SIZE;
          fld   = '0;
        end
      end
      P_SIZE: begin
        pay_total = pay_total | ({24'h000000, b} << (8 * fld));
        if (fld == 2'd3) begin
          seg_left = app_len - hdr_len - FRAME_OVERHEAD;
          later    = 1'b0;
          open_segment();
        end else begin
          fld = fld + 2'd1;
        end
      end
      P_FIRST, P_SEG: begin
        emit = 1'b1;
        if (pay_used != '1) pay_used = pay_used + 33'd1;
        seg_left = seg_left - 16'd1;
        if (seg_left == '0) close_segment();
      end
      P_MARK: begin
        if (pay_used != '1) pay_used = pay_used + 33'd1;
        case (fld)
          2'd0: begin
            if (b != SYNC_BYTE) abort_packet(ST_MISSING_MARK);
            else fld = 2'd1;
          end
          2'd1: begin
            if (b != marker_code) abort_packet(ST_MISSING_MARK);
            else fld = 2'd2;
          end
          2'd2: begin
            seg_left = {b, 8'h00};
            fld      = 2'd3;
          end
          default: begin
            seg_left = (seg_left | {8'h00, b}) - LEN_FIELD_LEN;
            later    = 1'b1;
            open_segment();
          end
        endcase
      end
      default: ;
    endcase

    if (emit && emitted != '1) emitted = emitted + 1'b1;

    if (lst && pkt_status == ST_OK) begin
      if (phase == P_HUNT)
        pkt_status = ST_NO_MARKER;
      else if (phase == P_LEN || phase == P_HDR || phase == P_SIZE ||
               phase == P_FIRST || phase == P_SEG)
        pkt_status = ST_CUT;
      else if (phase == P_MARK && fld != 2'd0)
        pkt_status = ST_SHORT_TAIL;
    end

    res.data_byte  = emit ? b : 8'h00;
    res.byte_valid = emit;
    res.packet_end = lst;
    res.status     = lst ? pkt_status : ST_OK;
    res.out_count  = emitted;

    if (lst) clear_packet();
    return emit || lst;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s differs, got 0x%0h expected 0x%0h", $time, what, got, want);
    fail_count_o++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (deframed_q.size() == 0) begin
      report_mismatch("result with no byte outstanding", 64'(got), '0);
    end else begin
      want = deframed_q.pop_front();
      checked_o++;
      if (got.data_byte !== want.data_byte)
        report_mismatch("data_byte", 64'(got.data_byte), 64'(want.data_byte));
      if (got.byte_valid !== want.byte_valid)
        report_mismatch("byte_valid", 64'(got.byte_valid), 64'(want.byte_valid));
      if (got.packet_end !== want.packet_end)
        report_mismatch("packet_end", 64'(got.packet_end), 64'(want.packet_end));
      if (got.status !== want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.out_count !== want.out_count)
        report_mismatch("out_count", 64'(got.out_count), 64'(want.out_count));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_code = MARKER_RESET;
      clear_packet();
      deframed_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) marker_code = cfg_data_i;
      if (out_valid_i && out_ready_i) check_result(out_item_i);
      if (in_valid_i && in_ready_i) begin
        if (deframe_byte(in_item_i.in_byte, in_item_i.in_last, next_res))
          deframed_q.push_back(next_res);
      end
      pending_o = deframed_q.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for app4_segment_payload_deframer_unit
// depends on apsd_pkg, the rtl top level and apsd_deframe_checker
module tb_top;
  import apsd_pkg::*;

  localparam int RANDOM_ITEMS = 1000;  // random bytes after the directed packets, ~1350 in all
  localparam int HOLD_CYCLES  = 100;   // long receiver hold-off, forces the block to back up
  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all before giving up
  localparam int SETTLE_WAIT  = 4;     // gives a resultless byte time to clear the pipe

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // block inputs start at known values
  logic       in_valid_i  = 1'b0;
  in_item_t   in_item_i   = '0;
  logic       out_ready_i = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic [7:0] cfg_data_i  = '0;

  logic       in_ready_o;
  logic       out_valid_o;
  out_item_t  out_item_o;
  logic       cfg_ready_o;

  int fail_count;
  int outstanding;
  int checked;

  app4_segment_payload_deframer_unit #(
    .OUT_COUNT_WIDTH(COUNT_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  apsd_deframe_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (outstanding),
    .checked_o    (checked)
  );

  // stimulus bookkeeping
  logic [7:0] pkt_bytes[$];  // packet being assembled, sent front to back
  logic [7:0] marker;        // marker code the block currently holds
  int         items_sent   = 0;
  int         packets_sent = 0;
  int         cfg_writes   = 0;
  int         burst_left   = 0;
  bit         no_gaps      = 1'b0;  // sender runs back to back while set
  bit         hold_req     = 1'b0;  // asks the receiver for its long hold-off
  bit         hold_done    = 1'b0;

  // ---------------------------------------------------------------------------
  // packet assembly
  // ---------------------------------------------------------------------------

  task automatic push(input logic [7:0] b);
    pkt_bytes.push_back(b);
  endtask

  // random bytes with no sync byte, so no marker pair can form by accident
  task automatic push_noise(input int n);
    logic [7:0] v;
    int i;
    for (i = 0; i < n; i++) begin
      v = 8'($urandom_range(0, 254));
      push(v);
    end
  endtask

  // fully random bytes: payload, trailing junk, raw noise packets
  task automatic push_data(input int n);
    logic [7:0] v;
    int i;
    for (i = 0; i < n; i++) begin
      v = 8'($urandom_range(0, 255));
      push(v);
    end
  endtask

  // sync, marker, big-endian segment length, header carrying its own length
  // little-endian at bytes 2 and 3, then the little-endian payload size
  task automatic push_head(input logic [15:0] app_len, input logic [15:0] hdr_field,
                           input int hdr_n, input logic [31:0] total);
    logic [7:0] v;
    int i;
    push(SYNC_BYTE);
    push(marker);
    push(app_len[15:8]);
    push(app_len[7:0]);
    for (i = 0; i < hdr_n; i++) begin
      v = 8'($urandom_range(0, 255));
      if (i == 2) push(hdr_field[7:0]);
      else if (i == 3) push(hdr_field[15:8]);
      else push(v);
    end
    for (i = 0; i < 4; i++) push(total[8*i +: 8]);
  endtask

  // opening of a later segment; the length counts its own two bytes
  task automatic push_seg_head(input logic [15:0] len_field);
    push(SYNC_BYTE);
    push(marker);
    push(len_field[15:8]);
    push(len_field[7:0]);
  endtask

  task automatic trim_to(input int n);
    while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
  endtask

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // one byte on the input channel; entered and left at a rising edge
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i  <= '{in_byte: b, in_last: lst};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // whole packet, last flag on its final byte
  task automatic send_packet();
    int i;
    for (i = 0; i < pkt_bytes.size(); i++) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    pkt_bytes.delete();
    packets_sent++;
  endtask

  // stop sending, let every outstanding result drain, then let the pipe empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  // marker code write, only ever issued while the block is idle
  task automatic write_marker(input logic [7:0] code);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= code;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    marker = code;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // random packets: some well framed with random content, the rest
  // carry one defect each (bad lengths, short header, cuts, flips, noise)
  // ---------------------------------------------------------------------------
  task automatic random_packet();
    int          hdr_n;
    int          first_n;
    int          n_later;
    int          flavor;
    int          idx;
    int          i;
    int          seg_n[3];
    logic [31:0] total;
    logic [15:0] app_len;
    logic [15:0] hdr_field;
    logic [15:0] len_field;
    logic [7:0]  flip;
    hdr_n   = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 64) : $urandom_range(4, 10);
    first_n = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 300) : $urandom_range(0, 12);
    n_later = $urandom_range(0, 3);
    total   = 32'(first_n);
    for (i = 0; i < n_later; i++) begin
      seg_n[i] = $urandom_range(0, 10);
      total    = total + 32'(4 + seg_n[i]);
    end
    flavor    = $urandom_range(0, 15);
    app_len   = 16'(hdr_n + 6 + first_n);
    hdr_field = 16'(hdr_n);
    case (flavor)
      9:  total = total + $urandom_range(1, 3);        // leaves a tail too short to frame
      10: total = $urandom_range(0, total + 8);        // size cuts early or runs past the data
      11: hdr_field = 16'($urandom_range(0, 3));       // header claims less than its own length
      12: app_len = 16'($urandom_range(0, hdr_n + 5)); // first segment length wraps
      13: total = $urandom;                            // size never reached
      default: ;
    endcase

    push_noise($urandom_range(0, 3));
    push_head(app_len, hdr_field, hdr_n, total);
    push_data(first_n);
    for (i = 0; i < n_later; i++) begin
      // later segment length of 0 or 1 wraps to a huge segment
      len_field = (flavor == 7 && i == 0) ? 16'($urandom_range(0, 1)) : 16'(seg_n[i] + 2);
      push_seg_head(len_field);
      push_data(seg_n[i]);
    end
    push_data($urandom_range(0, 3));

    if (flavor == 14) trim_to($urandom_range(1, pkt_bytes.size()));
    if (flavor == 15) begin
      idx  = $urandom_range(0, pkt_bytes.size() - 1);
      flip = 8'($urandom_range(1, 255));
      pkt_bytes[idx] = pkt_bytes[idx] ^ flip;
    end
    if (flavor == 8) begin
      // raw noise, sync bytes allowed
      pkt_bytes.delete();
      push_data($urandom_range(1, 24));
    end
    send_packet();
  endtask

  // ---------------------------------------------------------------------------
  // receiver: switches its stall pattern after each span of random length, and once
  // holds off for a long stretch on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int   mode;
    int   span;
    logic rdy;
    span = 0;
    mode = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 120);
      end
      span--;
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        case (mode)
          0:       rdy = 1'b1;                            // no stalls
          1:       rdy = 1'($urandom_range(0, 1));        // coin flip
          2:       rdy = ($urandom_range(0, 3) == 0);     // mostly stalled
          default: rdy = ($urandom_range(0, 7) != 0);     // occasional stall
        endcase
        out_ready_i <= rdy;
        @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run when no channel has moved for too long
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] plan[4];
    int         ph;
    int         goal;
    marker = MARKER_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed packets under the reset marker code

    // single byte, no marker anywhere
    push(8'h00);
    send_packet();
    // marker pair whose marker byte closes the packet
    push(SYNC_BYTE);
    push(marker);
    send_packet();
    // smallest clean packet, payload bytes at both extremes
    push_head(16'd13, 16'd4, 4, 32'd3);
    push(8'hFF);
    push(8'h00);
    push(8'hA5);
    send_packet();
    // header length below the minimum, the rest is dropped
    push_head(16'd20, 16'd3, 4, 32'd5);
    push_data(5);
    send_packet();
    // packet cut in the length field
    push(SYNC_BYTE);
    push(marker);
    push(8'h00);
    send_packet();
    // cut in the header
    push_head(16'd20, 16'd8, 8, 32'd4);
    trim_to(7);
    send_packet();
    // cut in the size field
    push_head(16'd20, 16'd4, 4, 32'd4);
    trim_to(10);
    send_packet();
    // cut inside the first segment
    push_head(16'd18, 16'd4, 4, 32'd8);
    push_data(4);
    send_packet();
    // first segment longer than the payload size, trailing bytes dropped
    push_head(16'd16, 16'd4, 4, 32'd2);
    push_data(6);
    push_data(3);
    send_packet();
    // two later segments, payload size met exactly
    push_head(16'd16, 16'd6, 6, 32'd20);
    push_data(4);
    push_seg_head(16'd5);
    push_data(3);
    push_seg_head(16'd7);
    push_data(5);
    send_packet();
    // bad sync byte where a later segment should open
    push_head(16'd12, 16'd4, 4, 32'd20);
    push_data(2);
    push(8'h12);
    push_data(4);
    send_packet();
    // bad marker byte in later framing
    push_head(16'd12, 16'd4, 4, 32'd20);
    push_data(2);
    push(SYNC_BYTE);
    push(~marker);
    push_data(3);
    send_packet();
    // two bytes of payload left after a later segment
    push_head(16'd12, 16'd4, 4, 32'd11);
    push_data(2);
    push_seg_head(16'd5);
    push_data(3);
    push_data(4);
    send_packet();
    // packet ends inside later framing
    push_head(16'd12, 16'd4, 4, 32'd30);
    push_data(2);
    push(SYNC_BYTE);
    push(marker);
    send_packet();
    // packet ends right at a segment boundary before the size is reached
    push_head(16'd13, 16'd4, 4, 32'd30);
    push_data(3);
    send_packet();
    // empty first segment, one short later segment
    push_head(16'd10, 16'd4, 4, 32'd5);
    push_seg_head(16'd3);
    push_data(1);
    send_packet();
    // empty later segment, then one whose length wraps
    push_head(16'd11, 16'd4, 4, 32'd40);
    push_data(1);
    push_seg_head(16'd2);
    push_seg_head(16'd1);
    push_data(5);
    send_packet();
    // first segment length wraps below header plus overhead
    push_head(16'd5, 16'd4, 4, 32'd3);
    push_data(4);
    send_packet();
    // payload size at its largest and at zero
    push_head(16'd12, 16'd4, 4, 32'hFFFF_FFFF);
    push_data(2);
    send_packet();
    push_head(16'd13, 16'd4, 4, 32'd0);
    push_data(3);
    push_data(2);
    send_packet();

    // marker code at its low extreme; sync bytes run back to back before the pair
    settle();
    write_marker(8'h00);
    push(8'h00);
    push(SYNC_BYTE);
    push_head(16'd13, 16'd4, 4, 32'd7);
    push_data(3);
    push_seg_head(16'd2);
    send_packet();

    // marker code at its high extreme, equal to the sync byte
    settle();
    write_marker(8'hFF);
    push_head(16'd12, 16'd4, 4, 32'd9);
    push_data(2);
    push_seg_head(16'd5);
    push_data(3);
    send_packet();

    // random part, split over several marker codes
    plan[0] = MARKER_RESET;
    plan[1] = 8'($urandom_range(0, 255));
    plan[2] = 8'h00;
    plan[3] = 8'hFF;
    for (ph = 0; ph < 4; ph++) begin
      settle();
      write_marker(plan[ph]);
      goal = items_sent + RANDOM_ITEMS / 4;
      if (ph == 0) begin
        // sender runs flat out into the long receiver hold-off
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        push_head(16'd160, 16'd4, 4, 32'd150);
        push_data(150);
        send_packet();
        no_gaps = 1'b0;
      end
      while (items_sent < goal) random_packet();
    end

    // drain and let the pipeline go quiet
    settle();
    repeat (8) @(posedge clk_i);

    $display("covered %0d packets, %0d bytes in, %0d marker codes, %0d results compared",
             packets_sent, items_sent, cfg_writes + 1, checked);
    if (fail_count == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/apsd_pkg.sv
rtl/apsd_parse.sv
rtl/app4_segment_payload_deframer_unit.sv
sim/apsd_deframe_checker.sv
sim/tb_top.sv
